/* rtl/marie_accumulator_cpu_step_top_macros.svh */
// Assertion macros for the accumulator CPU step block.
// The clocked forms sample on aclk; MARIE_ASSERT stays off while aresetn is low.
`ifndef MARIE_ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH
`define MARIE_ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising aclk edge outside reset.
`define MARIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every rising aclk edge, reset included.
`define MARIE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define MARIE_ASSERT(label, prop, msg)
`define MARIE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/marie_pkg.sv */
package marie_pkg;

    // Default geometry of the main memory
    localparam int ADDR_BITS_DEF = 12;
    localparam int WORD_BITS_DEF = 16;

    // Field widths on the stream ports
    localparam int OPN_W   = 2;
    localparam int INSTR_W = 16;
    localparam int OPND_W  = 12;
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 16;
    localparam int PC_W    = 12;

    // Packed channel widths, rounded up to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 64;

    // Item kinds carried on s_tuser
    typedef enum logic [OPN_W-1:0] {
        OPN_EXEC  = 2'd0,
        OPN_WRITE = 2'd1,
        OPN_READ  = 2'd2
    } opn_t;

    // Instruction opcodes, bits 15..12 of the instruction word
    typedef enum logic [3:0] {
        OPC_JNS      = 4'd0,
        OPC_LOAD     = 4'd1,
        OPC_STORE    = 4'd2,
        OPC_ADD      = 4'd3,
        OPC_SUBT     = 4'd4,
        OPC_INPUT    = 4'd5,
        OPC_OUTPUT   = 4'd6,
        OPC_HALT     = 4'd7,
        OPC_SKIPCOND = 4'd8,
        OPC_JUMP     = 4'd9,
        OPC_CLEAR    = 4'd10,
        OPC_ADDI     = 4'd11,
        OPC_JUMPI    = 4'd12,
        OPC_LOADI    = 4'd13,
        OPC_STOREI   = 4'd14,
        OPC_SPARE    = 4'd15
    } opcode_t;

    // Skipcond condition codes, bits 11..10
    localparam logic [1:0] COND_NEG  = 2'b00;
    localparam logic [1:0] COND_ZERO = 2'b01;
    localparam logic [1:0] COND_POS  = 2'b10;

    // Work left for an item after its first memory read
    typedef enum logic [2:0] {
        JOB_LOAD,
        JOB_ADD,
        JOB_SUBT,
        JOB_JUMPI,
        JOB_ADDI,
        JOB_LOADI,
        JOB_STOREI,
        JOB_READ
    } job_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2
    } state_t;

endpackage

/* rtl/marie_accumulator_cpu_step_top.sv */
// Channel  Dir  Ports                          Carries
// s_       in   s_tvalid s_tready s_tdata s_tuser  one operation item
// m_       out  m_tvalid m_tready m_tdata          one result item per input item
//
// Execute items without a memory read, write items and ignored items finish on
// accept; Load, Add, Subt, JumpI, StoreI and read items also use ST_RD1; AddI and
// LoadI use ST_RD1 and ST_RD2. The single port of the main memory sets this: each
// dependent read needs its own state. A new item is taken whenever the sequencer
// is idle and the two-entry result buffer has a free slot, so results waiting on
// m_ do not hold back the input until both slots are full. Reset clears the
// registers only; the main memory keeps no reset value and needs no clearing pass.
module marie_accumulator_cpu_step_top #(
    parameter int ADDR_BITS = marie_pkg::ADDR_BITS_DEF,
    parameter int WORD_BITS = marie_pkg::WORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] instruction, [27:16] address, [43:28] write_data,
    // [59:44] input_value, [63:60] zero
    input  logic [marie_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [marie_pkg::OPN_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] accumulator, [27:16] program_counter, [43:28] output_value,
    // [44] halted, [60:45] read_data, [63:61] zero
    output logic [marie_pkg::M_TDATA_W-1:0] m_tdata
);
    import marie_pkg::*;

    // input fields
    logic [INSTR_W-1:0]       in_instr;
    logic [ADDR_W-1:0]        in_addr;
    logic signed [DATA_W-1:0] in_wdata;
    logic signed [DATA_W-1:0] in_value;
    opn_t                     in_opn;
    opcode_t                  in_opc;
    logic [ADDR_BITS-1:0]     opnd;
    logic [ADDR_BITS-1:0]     item_addr;
    logic [ADDR_BITS:0]       opnd_inc;

    assign in_instr  = s_tdata[15:0];
    assign in_addr   = s_tdata[27:16];
    assign in_wdata  = s_tdata[43:28];
    assign in_value  = s_tdata[59:44];
    assign in_opn    = opn_t'(s_tuser);
    assign in_opc    = opcode_t'(in_instr[15:12]);
    assign opnd      = ADDR_BITS'(in_instr[OPND_W-1:0]);
    assign item_addr = ADDR_BITS'(in_addr);
    assign opnd_inc  = {1'b0, opnd} + (ADDR_BITS+1)'(1);

    // architectural state
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] pc_reg, pc_next;
    logic [WORD_BITS-1:0] out_reg, out_next;
    logic                 halt_reg, halt_next;
    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;

    // memory port and result path
    logic                 mem_en;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] rd_val;
    logic                 push;
    logic [M_TDATA_W-1:0] push_data;
    logic [1:0]           buf_level;
    logic                 s_fire;
    logic [ADDR_BITS-1:0] pc_inc;
    logic                 skip;

    assign s_tready = (state_reg == ST_IDLE) && (buf_level != 2'd2);
    assign s_fire   = s_tvalid && s_tready;
    assign pc_inc   = pc_reg + ADDR_BITS'(1);

    // skip test for Skipcond
    always_comb begin
        case (in_instr[11:10])
            COND_NEG:  skip = acc_reg[WORD_BITS-1];
            COND_ZERO: skip = (acc_reg == '0);
            COND_POS:  skip = !acc_reg[WORD_BITS-1] && (acc_reg != '0);
            default:   skip = 1'b0;
        endcase
    end

    // sequencer: decode on accept, finish memory work in RD1/RD2
    always_comb begin
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        out_next   = out_reg;
        halt_next  = halt_reg;
        state_next = state_reg;
        job_next   = job_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = opnd;
        mem_wdata  = acc_reg;
        rd_val     = '0;
        push       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_opn)
                        OPN_EXEC: begin
                            if (halt_reg) begin
                                push = 1'b1;
                            end else begin
                                pc_next = pc_inc;
                                push    = 1'b1;
                                case (in_opc)
                                    OPC_JNS: begin
                                        mem_en    = 1'b1;
                                        mem_we    = 1'b1;
                                        mem_wdata = WORD_BITS'(pc_inc);
                                        acc_next  = WORD_BITS'(opnd_inc);
                                        pc_next   = opnd_inc[ADDR_BITS-1:0];
                                    end
                                    OPC_STORE: begin
                                        mem_en = 1'b1;
                                        mem_we = 1'b1;
                                    end
                                    OPC_LOAD, OPC_ADD, OPC_SUBT, OPC_JUMPI,
                                    OPC_ADDI, OPC_LOADI, OPC_STOREI: begin
                                        mem_en     = 1'b1;
                                        push       = 1'b0;
                                        state_next = ST_RD1;
                                        case (in_opc)
                                            OPC_LOAD:  job_next = JOB_LOAD;
                                            OPC_ADD:   job_next = JOB_ADD;
                                            OPC_SUBT:  job_next = JOB_SUBT;
                                            OPC_JUMPI: job_next = JOB_JUMPI;
                                            OPC_ADDI:  job_next = JOB_ADDI;
                                            OPC_LOADI: job_next = JOB_LOADI;
                                            default:   job_next = JOB_STOREI;
                                        endcase
                                    end
                                    OPC_INPUT:    acc_next  = WORD_BITS'(in_value);
                                    OPC_OUTPUT:   out_next  = acc_reg;
                                    OPC_HALT:     halt_next = 1'b1;
                                    OPC_SKIPCOND: begin
                                        if (skip) begin
                                            pc_next = pc_inc + ADDR_BITS'(1);
                                        end
                                    end
                                    OPC_JUMP:     pc_next  = opnd;
                                    OPC_CLEAR:    acc_next = '0;
                                    default: ;
                                endcase
                            end
                        end
                        OPN_WRITE: begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_addr  = item_addr;
                            mem_wdata = WORD_BITS'(in_wdata);
                            push      = 1'b1;
                        end
                        OPN_READ: begin
                            mem_en     = 1'b1;
                            mem_addr   = item_addr;
                            job_next   = JOB_READ;
                            state_next = ST_RD1;
                        end
                        default: push = 1'b1;
                    endcase
                end
            end
            ST_RD1: begin
                push       = 1'b1;
                state_next = ST_IDLE;
                case (job_reg)
                    JOB_LOAD:  acc_next = mem_rdata;
                    JOB_ADD:   acc_next = acc_reg + mem_rdata;
                    JOB_SUBT:  acc_next = acc_reg - mem_rdata;
                    JOB_JUMPI: pc_next  = mem_rdata[ADDR_BITS-1:0];
                    JOB_ADDI, JOB_LOADI: begin
                        // pointer fetched, now read its target
                        mem_en     = 1'b1;
                        mem_addr   = mem_rdata[ADDR_BITS-1:0];
                        push       = 1'b0;
                        state_next = ST_RD2;
                    end
                    JOB_STOREI: begin
                        mem_en   = 1'b1;
                        mem_we   = 1'b1;
                        mem_addr = mem_rdata[ADDR_BITS-1:0];
                    end
                    default:   rd_val = mem_rdata;
                endcase
            end
            ST_RD2: begin
                push       = 1'b1;
                state_next = ST_IDLE;
                if (job_reg == JOB_ADDI) begin
                    acc_next = acc_reg + mem_rdata;
                end else begin
                    acc_next = mem_rdata;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            pc_reg    <= '0;
            out_reg   <= '0;
            halt_reg  <= 1'b0;
            state_reg <= ST_IDLE;
            job_reg   <= JOB_LOAD;
        end else begin
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            out_reg   <= out_next;
            halt_reg  <= halt_next;
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    // result item, built from the state after the step
    assign push_data = {3'b000,
                        rd_val[DATA_W-1:0],
                        halt_next,
                        out_next[DATA_W-1:0],
                        PC_W'(pc_next),
                        acc_next[DATA_W-1:0]};

    marie_ram #(
        .ADDR_BITS (ADDR_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    marie_out_buf #(
        .DATA_W (M_TDATA_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .level     (buf_level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // checks
    `include "marie_accumulator_cpu_step_top_macros.svh"

    `MARIE_ASSERT(a_halt_sticky, halt_reg |=> halt_reg, "halt flag cleared without reset")
    `MARIE_ASSERT(a_buf_no_overflow, (push && (buf_level == 2'd2)) |-> m_tready, "result buffer overflow")
    `MARIE_ASSERT(a_rd2_after_rd1, (state_reg == ST_RD2) |-> ($past(state_reg) == ST_RD1), "second read without pointer fetch")
    `MARIE_ASSERT_ALWAYS(a_reset_idle, (!aresetn) |=> (state_reg == ST_IDLE), "sequencer not idle after reset")

endmodule

/* rtl/marie_ram.sv */
// Single-port synchronous RAM with a registered read.
module marie_ram #(
    parameter int ADDR_BITS = marie_pkg::ADDR_BITS_DEF,
    parameter int WORD_BITS = marie_pkg::WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);
    import marie_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] rdata_reg;

    // write or read, never both in one cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/marie_out_buf.sv */
// Two-entry result buffer: output register plus skid slot.
module marie_out_buf #(
    parameter int DATA_W = marie_pkg::M_TDATA_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic [1:0]        level,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);
    import marie_pkg::*;

    logic [DATA_W-1:0] head_reg;
    logic [DATA_W-1:0] tail_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              pop;

    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // head feeds the port, tail catches an item while head is stalled
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push && (cnt_reg == 2'd0)) begin
            head_reg <= push_data;
        end
        if (push && (((cnt_reg == 2'd1) && !pop) || ((cnt_reg == 2'd2) && pop))) begin
            tail_reg <= push_data;
        end
    end

    assign level    = cnt_reg;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg;

endmodule
